>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is asserted
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked property, also evaluated around reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/s256_pkg.sv
// sha-256 constants and round functions
// no dependencies; used by the hasher top level and its checker
package s256_pkg;

    localparam int DIGEST_WORDS = 8;
    localparam int ROUNDS       = 64;
    localparam int LENGTH_AT    = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> rtl/sha256_stream_hasher.sv
// sha-256 hasher over a byte stream, one shared round unit under a sequencer
// depends on s256_pkg
//
// channel  direction  handshake                  payload
// in       to block   i_in_valid / o_in_stall    i_msg_byte, i_byte_present, i_end_of_message
// out      from block o_out_valid / i_out_stall  o_digest_word, o_word_index, o_last_word
//
// one byte item per cycle while the input is not stalled; a full block then runs 64 rounds and one hash update
// end of message: one padding byte per cycle (at most 72 over two blocks), a
// compression per full block, then 8 transfers
// input stalled during a compression and from end of message to the last digest word
// a stalled output holds word and index
// reset (synchronous, active low) loads the initial hash and clears count and length
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import s256_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_ROUND  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    localparam logic [5:0] FILL_LAST  = 6'(63);
    localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
    localparam logic [2:0] WORD_LAST  = 3'(DIGEST_WORDS - 1);

    logic [2:0]   r_state;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [5:0]   r_round;
    logic [2:0]   r_oidx;
    logic         r_pad;
    logic         r_marked;
    logic         r_len_blk;
    logic         r_final;
    logic [511:0] r_win;
    logic [31:0]  r_h [DIGEST_WORDS];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;

    logic         in_xfer;
    logic         out_xfer;
    logic         shift_en;
    logic         block_full;
    logic         len_blk_eff;
    logic [7:0]   pad_byte;
    logic [7:0]   shift_byte;
    logic [2:0]   len_sel;
    logic [31:0]  w0, w1, w9, w14, n_w;
    logic [31:0]  t1, t2;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_OUT);
    assign out_xfer   = o_out_valid && !i_out_stall;

    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == WORD_LAST);

    always_comb begin
        len_sel = 3'd7 - r_fill[2:0];
        if (!r_marked) begin
            pad_byte = PAD_BYTE;
        end else if (r_len_blk && r_fill >= 6'(LENGTH_AT)) begin
            pad_byte = r_bits[{len_sel, 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
        shift_en    = (in_xfer && i_byte_present) || (r_state == S_PAD);
        shift_byte  = (r_state == S_PAD) ? pad_byte : i_msg_byte;
        block_full  = shift_en && (r_fill == FILL_LAST);
        len_blk_eff = r_len_blk || (!r_marked && r_fill < 6'(LENGTH_AT));
    end

    // schedule taps and round arithmetic
    always_comb begin
        w0  = r_win[511:480];
        w1  = r_win[479:448];
        w9  = r_win[223:192];
        w14 = r_win[63:32];
        n_w = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
        t1  = r_hh + big_sigma1(r_e) + ((r_e & r_f) ^ (~r_e & r_g)) + K_ROUND[r_round] + w0;
        t2  = big_sigma0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_win <= {r_win[503:0], shift_byte};
        end else if (r_state == S_ROUND) begin
            r_win <= {r_win[479:0], n_w};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_round   <= '0;
            r_oidx    <= '0;
            r_pad     <= 1'b0;
            r_marked  <= 1'b0;
            r_len_blk <= 1'b0;
            r_final   <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            if (shift_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (block_full) begin
                r_round <= '0;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d  <= r_h[3];
                r_e <= r_h[4]; r_f <= r_h[5]; r_g <= r_h[6]; r_hh <= r_h[7];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_byte_present) begin
                            r_bits <= r_bits + 64'd8;
                        end
                        if (block_full) begin
                            r_state   <= S_ROUND;
                            r_pad     <= i_end_of_message;
                            r_marked  <= 1'b0;
                            r_len_blk <= 1'b0;
                            r_final   <= 1'b0;
                        end else if (i_end_of_message) begin
                            r_state   <= S_PAD;
                            r_pad     <= 1'b1;
                            r_marked  <= 1'b0;
                            r_len_blk <= 1'b0;
                            r_final   <= 1'b0;
                        end
                    end
                end
                S_PAD: begin
                    r_marked <= 1'b1;
                    if (block_full) begin
                        r_state   <= S_ROUND;
                        r_final   <= len_blk_eff;
                        // a block filled here without the length passes it on to the next block
                        r_len_blk <= 1'b1;
                    end else if (len_blk_eff) begin
                        r_len_blk <= 1'b1;
                    end
                end
                S_ROUND: begin
                    r_hh <= r_g;
                    r_g  <= r_f;
                    r_f  <= r_e;
                    r_e  <= r_d + t1;
                    r_d  <= r_c;
                    r_c  <= r_b;
                    r_b  <= r_a;
                    r_a  <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == ROUND_LAST) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_h[5] <= r_h[5] + r_f;
                    r_h[6] <= r_h[6] + r_g;
                    r_h[7] <= r_h[7] + r_hh;
                    if (r_final) begin
                        r_state <= S_OUT;
                        r_oidx  <= '0;
                    end else if (r_pad) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        if (r_oidx == WORD_LAST) begin
                            r_state   <= S_IDLE;
                            r_bits    <= '0;
                            r_fill    <= '0;
                            r_pad     <= 1'b0;
                            r_marked  <= 1'b0;
                            r_len_blk <= 1'b0;
                            r_final   <= 1'b0;
                            for (int i = 0; i < DIGEST_WORDS; i++) begin
                                r_h[i] <= H_INIT[i];
                            end
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/s256_checker.sv
// port-level checks for the sha-256 stream hasher, bound to its top level
// depends on s256_pkg and assert_macros.svh
`include "assert_macros.svh"

module s256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);
    import s256_pkg::*;

    localparam logic [2:0] IDX_LAST = 3'(DIGEST_WORDS - 1);

    // a stalled word stays offered
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digest_word)
        && $stable(o_word_index), "stalled digest word changed")

    `CHK_ASSERT(a_last_flag, i_clk, i_rst_n,
        o_out_valid |-> (o_last_word == (o_word_index == IDX_LAST)),
        "last flag does not match index")

    // no input transfer while the digest is being sent
    `CHK_ASSERT(a_busy_out, i_clk, i_rst_n, o_out_valid |-> o_in_stall,
        "input open during digest output")

    `CHK_ASSERT(a_word_seq, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_last_word |=> o_out_valid
        && (o_word_index == 3'($past(o_word_index) + 3'd1)), "digest words out of sequence")

    `CHK_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall,
        "block not idle after reset")

endmodule

bind sha256_stream_hasher s256_checker u_s256_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
